// ===== src/pbt_pkg.sv =====
// shared types, character codes and byte classes for the pdf byte tokenizer
`timescale 1ns / 1ps
`default_nettype none

package pbt_pkg;

   // character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // keyword match progress: length of "stream" and the no-match code
   localparam logic [2:0] KW_LEN  = 3'd6;
   localparam logic [2:0] KW_NONE = 3'd7;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // one classified input transaction
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        stream_end;
      logic        ws;
      logic        brk;
      logic [31:0] offset;
   } item_type;

   // one result transaction, without the last mark
   typedef struct packed {
      logic [7:0]  token_byte;
      logic        byte_valid;
      logic        token_first;
      logic        token_done;
      logic [31:0] token_offset;
      logic        stream_line_done;
      logic        error;
   } result_type;

   // whitespace class
   function automatic logic is_ws(input logic [7:0] b);
      return b inside {CH_NUL, CH_TAB, CH_LF, CH_FF, CH_CR, CH_SPACE};
   endfunction

   // delimiter class
   function automatic logic is_brk(input logic [7:0] b);
      return b inside {CH_LPAREN, CH_RPAREN, CH_LT, CH_GT, CH_RBRACK,
                       CH_LBRACK, CH_LBRACE, CH_RBRACE, CH_SLASH, CH_PCT};
   endfunction

   // letters of the stream keyword
   function automatic logic [7:0] kw_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h73;
         3'd1: c = 8'h74;
         3'd2: c = 8'h72;
         3'd3: c = 8'h65;
         3'd4: c = 8'h61;
         3'd5: c = 8'h6D;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== src/pbt_queue.sv =====
// small first-in first-out queue of classified transactions
`timescale 1ns / 1ps
`default_nettype none

module pbt_queue #(
   parameter int WIDTH = 43,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  rd_valid
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign full     = (count_ff == CW'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   // storage and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue fill count beyond depth");
`endif

endmodule

`default_nettype wire

// ===== src/pbt_front.sv =====
// front end: accepts stream transactions, classifies bytes and tags offsets
`timescale 1ns / 1ps
`default_nettype none

module pbt_front #(
   parameter int OFFSET_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         req_stream_end,
   input  wire logic         q_full,
   output logic              q_wr,
   output pbt_pkg::item_type q_item
);

   import pbt_pkg::*;

   logic [OFFSET_BITS-1:0] byte_count_ff, byte_count_in;
   logic [63:0]            count_wide;
   logic                   accept;

   assign accept     = push && !q_full;
   assign q_wr       = accept;
   assign count_wide = 64'(byte_count_ff);

   // classify the byte and tag it with its stream offset
   always_comb begin
      q_item.data_byte  = req_data_byte;
      q_item.stream_end = req_stream_end;
      q_item.ws         = is_ws(req_data_byte);
      q_item.brk        = is_brk(req_data_byte);
      q_item.offset     = count_wide[31:0];
   end

   // byte offset advances on every byte, not on end markers
   always_comb begin
      byte_count_in = byte_count_ff;
      if (accept && !req_stream_end) begin
         byte_count_in = byte_count_ff + OFFSET_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/pbt_back.sv =====
// back end: scanner state machine and two-slot result register
`timescale 1ns / 1ps
`default_nettype none

module pbt_back #(
   parameter int MAX_NESTING = 255
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pbt_pkg::item_type  q_item,
   input  wire logic               q_valid,
   output logic                    q_pop,
   output logic [7:0]              rsp_token_byte,
   output logic                    rsp_byte_valid,
   output logic                    rsp_token_first,
   output logic                    rsp_token_done,
   output logic [31:0]             rsp_token_offset,
   output logic                    rsp_stream_line_done,
   output logic                    rsp_error,
   output logic                    rsp_last,
   output logic                    empty,
   input  wire logic               pop
);

   import pbt_pkg::*;

   localparam int DW = $clog2(MAX_NESTING + 1);

   typedef enum logic [3:0] {
      M_IDLE      = 4'd0,
      M_REG       = 4'd1,
      M_COMMENT   = 4'd2,
      M_STR       = 4'd3,
      M_STR_BS    = 4'd4,
      M_STR_CR    = 4'd5,
      M_LT        = 4'd6,
      M_HEX       = 4'd7,
      M_GT        = 4'd8,
      M_STREAM_WS = 4'd9,
      M_STREAM_CR = 4'd10
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [2:0]  kw_ff, kw_in;
   logic [31:0] start_ff, start_in;
   result_type  res0_ff, res1_ff;
   logic [1:0]  rem_ff, rem_in;
   logic        head_ff, head_in;

   result_type  r0_in, r1_in;
   logic [1:0]  n_res;
   logic        pop_ok, commit;

   // start of a new token
   mode_type    st_mode;
   logic [DW-1:0] st_depth;
   logic [2:0]  st_kw;
   logic        st_done;
   result_type  st_res;

   // byte inside a literal string
   mode_type    sb_mode;
   logic [DW-1:0] sb_depth, sb_dec;
   logic        sb_emit, sb_done, sb_err;
   result_type  sb_res;

   // byte inside a hex string
   mode_type    hx_mode;
   logic        hx_emit, hx_done;
   result_type  hx_res;

   result_type  tok_res, end_res, info_res;
   logic [7:0]  b;
   logic [31:0] off;

   function automatic result_type mk_res(input logic [7:0] tb, input logic valid,
                                         input logic first, input logic done,
                                         input logic [31:0] toff, input logic line,
                                         input logic err);
      result_type r;
      r.token_byte       = valid ? tb : 8'h00;
      r.byte_valid       = valid;
      r.token_first      = first;
      r.token_done       = done;
      r.token_offset     = toff;
      r.stream_line_done = line;
      r.error            = err;
      return r;
   endfunction

   assign b = q_item.data_byte;
   assign off = q_item.offset;

   // helper results shared by several modes
   always_comb begin
      st_mode  = M_REG;
      st_depth = depth_ff;
      st_kw    = kw_ff;
      st_done  = 1'b0;
      case (b)
         CH_PCT:    st_mode = M_COMMENT;
         CH_LPAREN: begin
            st_mode  = M_STR;
            st_depth = DW'(1);
         end
         CH_LT:     st_mode = M_LT;
         CH_GT:     st_mode = M_GT;
         CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE: begin
            st_mode = M_IDLE;
            st_done = 1'b1;
         end
         default:   st_kw = (b == kw_char(3'd0)) ? 3'd1 : KW_NONE;
      endcase
      st_res = mk_res(b, 1'b1, 1'b1, st_done, off, 1'b0, 1'b0);

      sb_mode  = M_STR;
      sb_depth = depth_ff;
      sb_emit  = 1'b1;
      sb_done  = 1'b0;
      sb_err   = 1'b0;
      sb_dec   = (depth_ff != '0) ? depth_ff - DW'(1) : depth_ff;
      if (b == CH_BSLASH) begin
         sb_mode = M_STR_BS;
         sb_emit = 1'b0;
      end else if (b == CH_LPAREN) begin
         if (depth_ff >= DW'(MAX_NESTING)) begin
            sb_err = 1'b1;
         end else begin
            sb_depth = depth_ff + DW'(1);
         end
      end else if (b == CH_RPAREN) begin
         sb_depth = sb_dec;
         if (sb_dec == '0) begin
            sb_done = 1'b1;
            sb_mode = M_IDLE;
         end
      end
      sb_res = mk_res(b, 1'b1, 1'b0, sb_done, start_ff, 1'b0, sb_err);

      hx_mode = M_HEX;
      hx_emit = !q_item.ws;
      hx_done = 1'b0;
      if (b == CH_GT) begin
         hx_mode = M_IDLE;
         hx_emit = 1'b1;
         hx_done = 1'b1;
      end
      hx_res = mk_res(b, 1'b1, 1'b0, hx_done, start_ff, 1'b0, 1'b0);

      tok_res  = mk_res(b, 1'b1, 1'b0, 1'b0, start_ff, 1'b0, 1'b0);
      end_res  = mk_res(8'h00, 1'b0, 1'b0, 1'b1, start_ff, 1'b0, 1'b0);
      info_res = mk_res(8'h00, 1'b0, 1'b0, 1'b0, off, 1'b0, 1'b0);
   end

   // scanner next state and the results of the head transaction
   always_comb begin
      mode_in  = mode_ff;
      depth_in = depth_ff;
      kw_in    = kw_ff;
      start_in = start_ff;
      r0_in    = '0;
      r1_in    = '0;
      n_res    = 2'd0;
      if (q_item.stream_end) begin
         if (mode_ff inside {M_REG, M_COMMENT, M_STR, M_STR_BS, M_STR_CR,
                             M_LT, M_HEX, M_GT}) begin
            r0_in = end_res;
            n_res = 2'd1;
         end
         mode_in  = M_IDLE;
         depth_in = '0;
         kw_in    = 3'd0;
      end else begin
         case (mode_ff)
            M_REG: begin
               if (q_item.ws) begin
                  r0_in = end_res;
                  n_res = 2'd1;
                  mode_in = M_IDLE;
                  if (kw_ff == KW_LEN) begin
                     if (b == CH_LF) begin
                        r0_in.stream_line_done = 1'b1;
                     end else if (b == CH_CR) begin
                        r0_in.stream_line_done = 1'b1;
                        mode_in = M_STREAM_CR;
                     end else begin
                        mode_in = M_STREAM_WS;
                     end
                  end
               end else if (q_item.brk) begin
                  r0_in       = end_res;
                  r0_in.error = (kw_ff == KW_LEN);
                  r1_in       = st_res;
                  n_res       = 2'd2;
                  mode_in     = st_mode;
                  depth_in    = st_depth;
                  kw_in       = st_kw;
                  start_in    = off;
               end else begin
                  if (kw_ff < KW_LEN && b == kw_char(kw_ff)) begin
                     kw_in = kw_ff + 3'd1;
                  end else begin
                     kw_in = KW_NONE;
                  end
                  r0_in = tok_res;
                  n_res = 2'd1;
               end
            end
            M_COMMENT: begin
               n_res = 2'd1;
               if (b == CH_CR || b == CH_LF) begin
                  r0_in   = end_res;
                  mode_in = M_IDLE;
               end else begin
                  r0_in = tok_res;
               end
            end
            M_STR: begin
               r0_in    = sb_res;
               n_res    = {1'b0, sb_emit};
               mode_in  = sb_mode;
               depth_in = sb_depth;
            end
            M_STR_BS: begin
               if (b == CH_LF) begin
                  mode_in = M_STR;
               end else if (b == CH_CR) begin
                  mode_in = M_STR_CR;
               end else begin
                  r0_in   = mk_res(CH_BSLASH, 1'b1, 1'b0, 1'b0, start_ff, 1'b0, 1'b0);
                  r1_in   = tok_res;
                  n_res   = 2'd2;
                  mode_in = M_STR;
               end
            end
            M_STR_CR: begin
               mode_in = M_STR;
               if (b != CH_LF) begin
                  r0_in    = sb_res;
                  n_res    = {1'b0, sb_emit};
                  mode_in  = sb_mode;
                  depth_in = sb_depth;
               end
            end
            M_LT: begin
               if (b == CH_LT) begin
                  r0_in = mk_res(b, 1'b1, 1'b0, 1'b1, start_ff, 1'b0, 1'b0);
                  n_res = 2'd1;
                  mode_in = M_IDLE;
               end else begin
                  r0_in   = hx_res;
                  n_res   = {1'b0, hx_emit};
                  mode_in = hx_mode;
               end
            end
            M_HEX: begin
               r0_in   = hx_res;
               n_res   = {1'b0, hx_emit};
               mode_in = hx_mode;
            end
            M_GT: begin
               if (b == CH_GT) begin
                  r0_in = mk_res(b, 1'b1, 1'b0, 1'b1, start_ff, 1'b0, 1'b0);
                  n_res = 2'd1;
                  mode_in = M_IDLE;
               end else begin
                  // lone '>' closes, then the byte is taken as in idle
                  r0_in   = end_res;
                  n_res   = 2'd1;
                  mode_in = M_IDLE;
                  if (!q_item.ws) begin
                     r1_in    = st_res;
                     n_res    = 2'd2;
                     mode_in  = st_mode;
                     depth_in = st_depth;
                     kw_in    = st_kw;
                     start_in = off;
                  end
               end
            end
            M_STREAM_WS: begin
               if (b == CH_LF) begin
                  r0_in = info_res;
                  r0_in.stream_line_done = 1'b1;
                  n_res = 2'd1;
                  mode_in = M_IDLE;
               end else if (b == CH_CR) begin
                  r0_in = info_res;
                  r0_in.stream_line_done = 1'b1;
                  n_res = 2'd1;
                  mode_in = M_STREAM_CR;
               end else if (!q_item.ws) begin
                  r0_in       = info_res;
                  r0_in.error = 1'b1;
                  r1_in       = st_res;
                  n_res       = 2'd2;
                  mode_in     = st_mode;
                  depth_in    = st_depth;
                  kw_in       = st_kw;
                  start_in    = off;
               end
            end
            M_STREAM_CR: begin
               mode_in = M_IDLE;
               if (b != CH_LF && !q_item.ws) begin
                  r0_in    = st_res;
                  n_res    = 2'd1;
                  mode_in  = st_mode;
                  depth_in = st_depth;
                  kw_in    = st_kw;
                  start_in = off;
               end
            end
            default: begin
               // idle and unused codes
               mode_in = M_IDLE;
               if (!q_item.ws) begin
                  r0_in    = st_res;
                  n_res    = 2'd1;
                  mode_in  = st_mode;
                  depth_in = st_depth;
                  kw_in    = st_kw;
                  start_in = off;
               end
            end
         endcase
      end
   end

   // take the head transaction once the result slots can hold its results
   always_comb begin
      pop_ok  = pop && !empty;
      commit  = q_valid && (n_res == 2'd0 || rem_ff == 2'd0 ||
                            (rem_ff == 2'd1 && pop_ok));
      q_pop   = commit;
      rem_in  = rem_ff;
      head_in = head_ff;
      if (commit && n_res != 2'd0) begin
         rem_in  = n_res;
         head_in = 1'b0;
      end else if (pop_ok) begin
         rem_in  = rem_ff - 2'd1;
         head_in = 1'b1;
      end
   end

   // scanner state and result slots
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         depth_ff <= '0;
         kw_ff    <= 3'd0;
         start_ff <= '0;
         rem_ff   <= 2'd0;
         head_ff  <= 1'b0;
      end else begin
         if (commit) begin
            mode_ff  <= mode_in;
            depth_ff <= depth_in;
            kw_ff    <= kw_in;
            start_ff <= start_in;
         end
         rem_ff  <= rem_in;
         head_ff <= head_in;
      end
      if (commit && n_res != 2'd0) begin
         res0_ff <= r0_in;
         res1_ff <= r1_in;
      end
   end

   // oldest waiting result on the ports
   result_type cur;
   assign cur                  = head_ff ? res1_ff : res0_ff;
   assign empty                = (rem_ff == 2'd0);
   assign rsp_token_byte       = cur.token_byte;
   assign rsp_byte_valid       = cur.byte_valid;
   assign rsp_token_first      = cur.token_first;
   assign rsp_token_done       = cur.token_done;
   assign rsp_token_offset     = cur.token_offset;
   assign rsp_stream_line_done = cur.stream_line_done;
   assign rsp_error            = cur.error;
   assign rsp_last             = (rem_ff == 2'd1);

`ifndef ASSERT_OFF
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(MAX_NESTING))
      else $error("paren depth beyond nesting limit");

   a_idle_depth: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == M_IDLE) |-> (depth_ff == '0))
      else $error("paren depth left open outside a string");

   a_first_has_byte: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_token_first) |-> rsp_byte_valid)
      else $error("token start without a byte");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (rem_ff == 2'd2) |-> !head_ff)
      else $error("second result slot shown before the first");
`endif

endmodule

`default_nettype wire

// ===== src/pdf_byte_tokenizer.sv =====
// pdf_byte_tokenizer top level: a lexical tokenizer for PDF byte streams.
// Each input transaction carries one stream byte or an end marker; the block
// returns token bytes with first and done marks, the offset of each token's
// first byte, and flags for the line end after the stream keyword and for
// errors. Each transaction yields zero, one or two results, the last marked
// with rsp_last. A transaction is accepted every cycle while the four-entry
// queue between the classifier front end and the scanner back end has room;
// the scanner takes one transaction per cycle while the result register can hold
// its results, and its first result passes through the queue and then the result
// register to the result ports. Results leave one per cycle while pop is high, so
// a transaction that gives two results fills both slots of the result register,
// and sustained throughput is one result per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pdf_byte_tokenizer #(
   parameter int MAX_NESTING = 255,
   parameter int OFFSET_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_stream_end,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_token_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_token_first,
   output logic             rsp_token_done,
   output logic [31:0]      rsp_token_offset,
   output logic             rsp_stream_line_done,
   output logic             rsp_error,
   output logic             rsp_last
);

   import pbt_pkg::*;

   logic     q_wr, q_pop, q_valid;
   item_type wr_item, rd_item;

   // classifier front end
   pbt_front #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .req_data_byte  (req_data_byte),
      .req_stream_end (req_stream_end),
      .q_full         (full),
      .q_wr           (q_wr),
      .q_item         (wr_item)
   );

   // queue between front and back
   pbt_queue #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_wr),
      .wr_data  (wr_item),
      .full     (full),
      .rd_en    (q_pop),
      .rd_data  (rd_item),
      .rd_valid (q_valid)
   );

   // scanner back end
   pbt_back #(
      .MAX_NESTING (MAX_NESTING)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_item               (rd_item),
      .q_valid              (q_valid),
      .q_pop                (q_pop),
      .rsp_token_byte       (rsp_token_byte),
      .rsp_byte_valid       (rsp_byte_valid),
      .rsp_token_first      (rsp_token_first),
      .rsp_token_done       (rsp_token_done),
      .rsp_token_offset     (rsp_token_offset),
      .rsp_stream_line_done (rsp_stream_line_done),
      .rsp_error            (rsp_error),
      .rsp_last             (rsp_last),
      .empty                (empty),
      .pop                  (pop)
   );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for pdf_byte_tokenizer: directed table, random token streams
`timescale 1ns / 1ps

module tb_top;
   import pbt_pkg::*;

   localparam int          NEST_LIMIT   = 255;
   localparam int          RANDOM_ITEMS = 500;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          TAIL_CYCLES  = 40;
   localparam logic [47:0] KEYWORD      = "stream";

   // scanner modes of the predictor
   typedef enum logic [3:0] {
      SCAN_IDLE,
      SCAN_REG,
      SCAN_COMMENT,
      SCAN_STR,
      SCAN_STR_BS,
      SCAN_STR_CR,
      SCAN_LT,
      SCAN_HEX,
      SCAN_GT,
      SCAN_STREAM_WS,
      SCAN_STREAM_CR
   } scan_mode_type;

   typedef struct packed {
      result_type rsp;
      logic       last;
   } expected_rsp_type;

   // one input transaction, with an optional typed-in expectation
   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
      logic       drain;
      logic       typed;
      result_type rsp;
   } stim_item_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        push           = 1'b0;
   logic [7:0]  req_data_byte  = 8'h00;
   logic        req_stream_end = 1'b0;
   logic        pop            = 1'b0;
   logic        full;
   logic        empty;
   logic [7:0]  rsp_token_byte;
   logic        rsp_byte_valid;
   logic        rsp_token_first;
   logic        rsp_token_done;
   logic [31:0] rsp_token_offset;
   logic        rsp_stream_line_done;
   logic        rsp_error;
   logic        rsp_last;

   // predictor state
   scan_mode_type scan_mode   = SCAN_IDLE;
   logic [15:0]   paren_depth = '0;
   logic [2:0]    kw_progress = '0;
   logic [31:0]   byte_count  = '0;
   logic [31:0]   token_start = '0;

   expected_rsp_type step_out[$];
   expected_rsp_type expected_tokens[$];
   stim_item_type    stim_q[$];
   logic             drain_next  = 1'b0;
   int               error_count = 0;
   int unsigned      cycle_count = 0;

   pdf_byte_tokenizer #(
      .MAX_NESTING(NEST_LIMIT),
      .OFFSET_BITS(32)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_data_byte        (req_data_byte),
      .req_stream_end       (req_stream_end),
      .empty                (empty),
      .pop                  (pop),
      .rsp_token_byte       (rsp_token_byte),
      .rsp_byte_valid       (rsp_byte_valid),
      .rsp_token_first      (rsp_token_first),
      .rsp_token_done       (rsp_token_done),
      .rsp_token_offset     (rsp_token_offset),
      .rsp_stream_line_done (rsp_stream_line_done),
      .rsp_error            (rsp_error),
      .rsp_last             (rsp_last)
   );

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // byte classes
   function automatic logic ws_byte(input logic [7:0] b);
      return b == CH_NUL || b == CH_TAB || b == CH_LF || b == CH_FF ||
             b == CH_CR || b == CH_SPACE;
   endfunction

   function automatic logic delim_byte(input logic [7:0] b);
      return b == CH_LPAREN || b == CH_RPAREN || b == CH_LT || b == CH_GT ||
             b == CH_LBRACK || b == CH_RBRACK || b == CH_LBRACE ||
             b == CH_RBRACE || b == CH_SLASH || b == CH_PCT;
   endfunction

   function automatic logic [7:0] keyword_at(input logic [2:0] idx);
      return KEYWORD[47 - 8 * int'(idx) -: 8];
   endfunction

   function automatic result_type make_rsp(input logic [7:0] b, input logic valid,
                                           input logic first, input logic done,
                                           input logic [31:0] off, input logic line,
                                           input logic err);
      result_type r;
      r.token_byte       = valid ? b : 8'h00;
      r.byte_valid       = valid;
      r.token_first      = first;
      r.token_done       = done;
      r.token_offset     = off;
      r.stream_line_done = line;
      r.error            = err;
      return r;
   endfunction

   // at most two results per transaction
   task automatic emit_rsp(input logic [7:0] b, input logic valid, input logic first,
                           input logic done, input logic [31:0] off, input logic line,
                           input logic err);
      expected_rsp_type e;
      if (step_out.size() < 2) begin
         e.rsp  = make_rsp(b, valid, first, done, off, line, err);
         e.last = 1'b0;
         step_out.push_back(e);
      end
   endtask

   task automatic token_text(input logic [7:0] b, input logic done, input logic err);
      emit_rsp(b, 1'b1, 1'b0, done, token_start, 1'b0, err);
   endtask

   task automatic close_token(input logic line, input logic err);
      emit_rsp(8'h00, 1'b0, 1'b0, 1'b1, token_start, line, err);
   endtask

   task automatic start_token(input logic [7:0] b, input logic [31:0] off);
      token_start = off;
      if (b == CH_PCT) begin
         emit_rsp(b, 1'b1, 1'b1, 1'b0, off, 1'b0, 1'b0);
         scan_mode = SCAN_COMMENT;
      end else if (b == CH_LPAREN) begin
         paren_depth = 16'd1;
         emit_rsp(b, 1'b1, 1'b1, 1'b0, off, 1'b0, 1'b0);
         scan_mode = SCAN_STR;
      end else if (b == CH_LT) begin
         emit_rsp(b, 1'b1, 1'b1, 1'b0, off, 1'b0, 1'b0);
         scan_mode = SCAN_LT;
      end else if (b == CH_GT) begin
         emit_rsp(b, 1'b1, 1'b1, 1'b0, off, 1'b0, 1'b0);
         scan_mode = SCAN_GT;
      end else if (b == CH_LBRACK || b == CH_RBRACK || b == CH_LBRACE || b == CH_RBRACE) begin
         emit_rsp(b, 1'b1, 1'b1, 1'b1, off, 1'b0, 1'b0);
         scan_mode = SCAN_IDLE;
      end else begin
         kw_progress = (b == keyword_at(3'd0)) ? 3'd1 : KW_NONE;
         emit_rsp(b, 1'b1, 1'b1, 1'b0, off, 1'b0, 1'b0);
         scan_mode = SCAN_REG;
      end
   endtask

   task automatic idle_byte(input logic [7:0] b, input logic [31:0] off);
      scan_mode = SCAN_IDLE;
      if (!ws_byte(b)) start_token(b, off);
   endtask

   // literal string body: nesting saturates with an error
   task automatic string_byte(input logic [7:0] b);
      if (b == CH_BSLASH) begin
         scan_mode = SCAN_STR_BS;
      end else if (b == CH_LPAREN) begin
         if (paren_depth >= NEST_LIMIT) begin
            token_text(b, 1'b0, 1'b1);
         end else begin
            paren_depth = paren_depth + 16'd1;
            token_text(b, 1'b0, 1'b0);
         end
      end else if (b == CH_RPAREN) begin
         if (paren_depth > 0) paren_depth = paren_depth - 16'd1;
         if (paren_depth == 0) begin
            token_text(b, 1'b1, 1'b0);
            scan_mode = SCAN_IDLE;
         end else begin
            token_text(b, 1'b0, 1'b0);
         end
      end else begin
         token_text(b, 1'b0, 1'b0);
      end
   endtask

   task automatic hex_byte(input logic [7:0] b);
      scan_mode = SCAN_HEX;
      if (b == CH_GT) begin
         token_text(b, 1'b1, 1'b0);
         scan_mode = SCAN_IDLE;
      end else if (!ws_byte(b)) begin
         token_text(b, 1'b0, 1'b0);
      end
   endtask

   // predict the results of one input transaction into step_out
   task automatic tokenize_byte(input logic [7:0] b, input logic se);
      logic [31:0]      off;
      expected_rsp_type e;
      off = byte_count;
      step_out.delete();
      if (se) begin
         case (scan_mode)
            SCAN_IDLE, SCAN_STREAM_WS, SCAN_STREAM_CR: ;
            default: close_token(1'b0, 1'b0);
         endcase
         scan_mode   = SCAN_IDLE;
         paren_depth = '0;
         kw_progress = 3'd0;
      end else begin
         case (scan_mode)
            SCAN_REG: begin
               if (ws_byte(b)) begin
                  if (kw_progress == KW_LEN) begin
                     if (b == CH_LF) begin
                        close_token(1'b1, 1'b0);
                        scan_mode = SCAN_IDLE;
                     end else if (b == CH_CR) begin
                        close_token(1'b1, 1'b0);
                        scan_mode = SCAN_STREAM_CR;
                     end else begin
                        close_token(1'b0, 1'b0);
                        scan_mode = SCAN_STREAM_WS;
                     end
                  end else begin
                     close_token(1'b0, 1'b0);
                     scan_mode = SCAN_IDLE;
                  end
               end else if (delim_byte(b)) begin
                  close_token(1'b0, kw_progress == KW_LEN);
                  start_token(b, off);
               end else begin
                  if (kw_progress < KW_LEN && b == keyword_at(kw_progress))
                     kw_progress = kw_progress + 3'd1;
                  else
                     kw_progress = KW_NONE;
                  token_text(b, 1'b0, 1'b0);
               end
            end
            SCAN_COMMENT: begin
               if (b == CH_CR || b == CH_LF) begin
                  close_token(1'b0, 1'b0);
                  scan_mode = SCAN_IDLE;
               end else begin
                  token_text(b, 1'b0, 1'b0);
               end
            end
            SCAN_STR: string_byte(b);
            SCAN_STR_BS: begin
               if (b == CH_LF) begin
                  scan_mode = SCAN_STR;
               end else if (b == CH_CR) begin
                  scan_mode = SCAN_STR_CR;
               end else begin
                  token_text(CH_BSLASH, 1'b0, 1'b0);
                  token_text(b, 1'b0, 1'b0);
                  scan_mode = SCAN_STR;
               end
            end
            SCAN_STR_CR: begin
               scan_mode = SCAN_STR;
               if (b != CH_LF) string_byte(b);
            end
            SCAN_LT: begin
               if (b == CH_LT) begin
                  token_text(b, 1'b1, 1'b0);
                  scan_mode = SCAN_IDLE;
               end else begin
                  hex_byte(b);
               end
            end
            SCAN_HEX: hex_byte(b);
            SCAN_GT: begin
               if (b == CH_GT) begin
                  token_text(b, 1'b1, 1'b0);
                  scan_mode = SCAN_IDLE;
               end else begin
                  close_token(1'b0, 1'b0);
                  idle_byte(b, off);
               end
            end
            SCAN_STREAM_WS: begin
               if (b == CH_LF) begin
                  emit_rsp(8'h00, 1'b0, 1'b0, 1'b0, off, 1'b1, 1'b0);
                  scan_mode = SCAN_IDLE;
               end else if (b == CH_CR) begin
                  emit_rsp(8'h00, 1'b0, 1'b0, 1'b0, off, 1'b1, 1'b0);
                  scan_mode = SCAN_STREAM_CR;
               end else if (!ws_byte(b)) begin
                  emit_rsp(8'h00, 1'b0, 1'b0, 1'b0, off, 1'b0, 1'b1);
                  start_token(b, off);
               end
            end
            SCAN_STREAM_CR: begin
               scan_mode = SCAN_IDLE;
               if (b != CH_LF) idle_byte(b, off);
            end
            default: idle_byte(b, off);
         endcase
         byte_count = byte_count + 32'd1;
      end
      // mark the last result of this transaction
      if (step_out.size() > 0) begin
         e = step_out.pop_back();
         e.last = 1'b1;
         step_out.push_back(e);
      end
   endtask

   // stimulus queue fill
   task automatic queue_row(input logic [7:0] b, input logic se, input logic typed,
                            input result_type r);
      stim_item_type it;
      it.data_byte  = b;
      it.stream_end = se;
      it.drain      = drain_next;
      it.typed      = typed;
      it.rsp        = r;
      drain_next    = 1'b0;
      stim_q.push_back(it);
   endtask

   task automatic queue_byte(input logic [7:0] b);
      queue_row(b, 1'b0, 1'b0, '0);
   endtask

   task automatic queue_end();
      queue_row(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
   endtask

   function automatic logic [7:0] pick_regular();
      logic [7:0] c;
      do c = 8'($urandom_range(8'h21, 8'h7E)); while (delim_byte(c));
      return c;
   endfunction

   function automatic logic [7:0] pick_ws();
      case ($urandom_range(0, 5))
         0: return CH_NUL;
         1: return CH_TAB;
         2: return CH_LF;
         3: return CH_FF;
         4: return CH_CR;
         default: return CH_SPACE;
      endcase
   endfunction

   // random part: mostly well-formed tokens with random content, some noise
   task automatic build_random();
      int         first_idx;
      int         n;
      int         depth;
      int         v;
      int         d;
      logic       deep_done;
      logic [7:0] c;
      first_idx  = stim_q.size();
      deep_done  = 1'b0;
      drain_next = 1'b1;
      while (stim_q.size() - first_idx < RANDOM_ITEMS) begin
         if (!deep_done && stim_q.size() - first_idx > 150) begin
            // nesting past the limit, then a couple of closes and an end marker
            deep_done = 1'b1;
            repeat (NEST_LIMIT + 3) queue_byte(CH_LPAREN);
            repeat (2) queue_byte(CH_RPAREN);
            queue_end();
         end else begin
            case ($urandom_range(0, 19))
               // regular word, sometimes a keyword prefix
               0, 1, 2, 3, 19: begin
                  if ($urandom_range(0, 9) == 0) drain_next = 1'b1;
                  n = $urandom_range(1, 6);
                  for (int i = 0; i < n; i++)
                     queue_byte(($urandom_range(0, 1) == 0 && i < 6) ? keyword_at(3'(i))
                                                                     : pick_regular());
                  if ($urandom_range(0, 1) == 0) queue_byte(pick_ws());
               end
               // stream keyword and what follows it
               4, 5, 6: begin
                  v = $urandom_range(0, 11);
                  queue_byte(CH_SPACE);
                  n = (v == 8) ? 5 : 6;
                  for (int i = 0; i < n; i++) queue_byte(keyword_at(3'(i)));
                  case (v)
                     0: queue_byte(CH_LF);
                     1: begin queue_byte(CH_CR); queue_byte(CH_LF); end
                     2: begin queue_byte(CH_CR); queue_byte(pick_regular()); end
                     3: begin queue_byte(CH_SPACE); queue_byte(CH_LF); end
                     4: begin
                        queue_byte(CH_SPACE);
                        queue_byte(CH_TAB);
                        queue_byte(CH_CR);
                        queue_byte(CH_LF);
                     end
                     5: begin queue_byte(pick_ws()); queue_byte(pick_regular()); end
                     6: begin
                        case ($urandom_range(0, 4))
                           0: queue_byte(CH_SLASH);
                           1: queue_byte(CH_LBRACK);
                           2: queue_byte(CH_RBRACK);
                           3: queue_byte(CH_LBRACE);
                           default: queue_byte(CH_RBRACE);
                        endcase
                     end
                     7: begin
                        queue_byte(CH_SPACE);
                        queue_byte(CH_FF);
                        queue_byte(CH_CR);
                        queue_byte(pick_regular());
                     end
                     8: queue_byte(pick_ws());
                     9: begin queue_byte(keyword_at(3'd0)); queue_byte(CH_SPACE); end
                     10: begin queue_byte(CH_SPACE); queue_end(); end
                     default: begin queue_byte(CH_CR); queue_end(); end
                  endcase
               end
               // literal string with nesting, escapes and line continuations
               7, 8, 9: begin
                  queue_byte(CH_LPAREN);
                  depth = 1;
                  n = $urandom_range(0, 10);
                  for (int i = 0; i < n; i++) begin
                     v = $urandom_range(0, 9);
                     if (v == 4 && depth < 5) begin
                        queue_byte(CH_LPAREN);
                        depth++;
                     end else if (v == 5 && depth > 1) begin
                        queue_byte(CH_RPAREN);
                        depth--;
                     end else if (v == 6) begin
                        queue_byte(CH_BSLASH);
                        queue_byte(8'($urandom_range(0, 255)));
                     end else if (v == 7) begin
                        queue_byte(CH_BSLASH);
                        queue_byte(CH_LF);
                     end else if (v == 8) begin
                        queue_byte(CH_BSLASH);
                        queue_byte(CH_CR);
                        queue_byte(CH_LF);
                     end else begin
                        if (v == 9) begin
                           queue_byte(CH_BSLASH);
                           queue_byte(CH_CR);
                        end
                        do c = 8'($urandom_range(0, 255));
                        while (c == CH_BSLASH || c == CH_LPAREN || c == CH_RPAREN);
                        queue_byte(c);
                     end
                  end
                  repeat (depth) queue_byte(CH_RPAREN);
               end
               // hex string with whitespace
               10, 11: begin
                  queue_byte(CH_LT);
                  n = $urandom_range(0, 8);
                  for (int i = 0; i < n; i++) begin
                     d = $urandom_range(0, 15);
                     if ($urandom_range(0, 2) == 0)
                        queue_byte(pick_ws());
                     else
                        queue_byte((d < 10) ? 8'(8'h30 + d) : 8'(8'h41 + d - 10));
                  end
                  queue_byte(CH_GT);
               end
               // markers of their own
               12, 13: begin
                  case ($urandom_range(0, 5))
                     0: begin queue_byte(CH_LT); queue_byte(CH_LT); end
                     1: begin queue_byte(CH_GT); queue_byte(CH_GT); end
                     2: begin queue_byte(CH_GT); queue_byte(pick_regular()); end
                     3: queue_byte(CH_LBRACK);
                     4: queue_byte(CH_RBRACK);
                     default: queue_byte(($urandom_range(0, 1) == 0) ? CH_LBRACE : CH_RBRACE);
                  endcase
               end
               // comment up to a line end
               14: begin
                  queue_byte(CH_PCT);
                  n = $urandom_range(0, 8);
                  for (int i = 0; i < n; i++) begin
                     do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
                     queue_byte(c);
                  end
                  queue_byte(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
               end
               // raw noise
               15, 16: begin
                  n = $urandom_range(1, 5);
                  repeat (n) queue_byte(8'($urandom_range(0, 255)));
               end
               17: queue_end();
               default: queue_byte(pick_ws());
            endcase
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         error_count++;
      end
   endtask

   // compare one accepted result transaction with the oldest expectation
   task automatic check_token_rsp();
      expected_rsp_type e;
      if (expected_tokens.size() == 0) begin
         $error("unexpected result transaction: token_byte %h offset %h",
                rsp_token_byte, rsp_token_offset);
         error_count++;
      end else begin
         e = expected_tokens.pop_front();
         check_field("token_byte", 32'(e.rsp.token_byte), 32'(rsp_token_byte));
         check_field("byte_valid", 32'(e.rsp.byte_valid), 32'(rsp_byte_valid));
         check_field("token_first", 32'(e.rsp.token_first), 32'(rsp_token_first));
         check_field("token_done", 32'(e.rsp.token_done), 32'(rsp_token_done));
         check_field("token_offset", e.rsp.token_offset, rsp_token_offset);
         check_field("stream_line_done", 32'(e.rsp.stream_line_done),
                     32'(rsp_stream_line_done));
         check_field("error", 32'(e.rsp.error), 32'(rsp_error));
         check_field("last", 32'(e.last), 32'(rsp_last));
      end
   endtask

   // sender: directed table, then random stream
   initial begin : sender
      stim_item_type    item;
      expected_rsp_type e;
      int               gap;
      int               sent;
      logic             quiet;

      // directed table; offsets count from zero after reset
      queue_row(CH_LBRACK, 1'b0, 1'b1,
                make_rsp(CH_LBRACK, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0, 1'b0));
      queue_row(8'hFF, 1'b0, 1'b1,
                make_rsp(8'hFF, 1'b1, 1'b1, 1'b0, 32'd1, 1'b0, 1'b0));
      // delimiter ends the open token
      queue_byte(CH_LPAREN);
      // escaped byte, then backslash-cr-lf continuation
      queue_byte(CH_BSLASH);
      queue_byte(CH_NUL);
      queue_byte(CH_BSLASH);
      queue_byte(CH_CR);
      queue_byte(CH_LF);
      queue_byte(CH_RPAREN);
      // lone close angle, then a comment
      queue_byte(CH_GT);
      queue_byte(CH_PCT);
      queue_byte(CH_LF);
      // hex string with whitespace right after the open angle
      queue_byte(CH_LT);
      queue_byte(CH_TAB);
      queue_byte("A");
      queue_byte(CH_GT);
      // stream keyword, whitespace, then a later line end
      for (int i = 0; i < 6; i++) queue_byte(keyword_at(3'(i)));
      queue_byte(CH_SPACE);
      queue_byte(CH_CR);
      queue_row(CH_RBRACE, 1'b0, 1'b1,
                make_rsp(CH_RBRACE, 1'b1, 1'b1, 1'b1, 32'd24, 1'b0, 1'b0));
      // end marker while idle, then while a token is open
      queue_end();
      queue_byte(CH_SLASH);
      queue_row(8'h00, 1'b1, 1'b1,
                make_rsp(8'h00, 1'b0, 1'b0, 1'b1, 32'd25, 1'b0, 1'b0));
      build_random();

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      quiet = 1'b0;
      sent  = 0;
      while (stim_q.size() != 0) begin
         item = stim_q.pop_front();
         if (sent % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
         gap = quiet ? 0 : $urandom_range(0, 11);
         // idle gap, and a full drain where asked
         if (item.drain || gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
            if (item.drain)
               do @(posedge clock); while (expected_tokens.size() != 0);
         end
         push           <= 1'b1;
         req_data_byte  <= item.data_byte;
         req_stream_end <= item.stream_end;
         do @(posedge clock); while (full);
         // transaction accepted: predict
         tokenize_byte(item.data_byte, item.stream_end);
         if (item.typed) begin
            e.rsp  = item.rsp;
            e.last = 1'b1;
            expected_tokens.push_back(e);
         end else begin
            foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
         end
         sent++;
      end
      push <= 1'b0;

      // wait out the remaining results and any stray ones
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // receiver: random stalls, check every accepted result
   initial begin : receiver
      int   gap;
      int   taken;
      logic quiet;
      quiet = 1'b0;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
         gap = quiet ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         check_token_rsp();
         taken++;
      end
   end

endmodule
